// File: hw/rtl/vdg_pkg.sv
// Shared types, codes and the color table of the pixel generator.
`default_nettype none

package vdg_pkg;

   localparam int GLYPH_COUNT = 64;
   localparam int LINE_PIXELS = 16;

   // Input item commands
   localparam logic CMD_RENDER     = 1'b0;
   localparam logic CMD_FONT_WRITE = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_GRAPHICS_ENABLE = 2'd0;
   localparam logic [1:0] CSR_GRAPHICS_MODE   = 2'd1;
   localparam logic [1:0] CSR_COLOUR_SET      = 2'd2;
   localparam logic [1:0] CSR_FONT_PRESENT    = 2'd3;

   // GM2:GM0 codes
   localparam logic [2:0] GM_CG1 = 3'd0;
   localparam logic [2:0] GM_RG6 = 3'd7;

   // Color indexes
   localparam logic [3:0] COLOUR_GREEN   = 4'd0;
   localparam logic [3:0] COLOUR_YELLOW  = 4'd1;
   localparam logic [3:0] COLOUR_BLUE    = 4'd2;
   localparam logic [3:0] COLOUR_RED     = 4'd3;
   localparam logic [3:0] COLOUR_BUFF    = 4'd4;
   localparam logic [3:0] COLOUR_CYAN    = 4'd5;
   localparam logic [3:0] COLOUR_MAGENTA = 4'd6;
   localparam logic [3:0] COLOUR_ORANGE  = 4'd7;
   localparam logic [3:0] COLOUR_BLACK   = 4'd8;

   localparam logic [7:0] BOX_EDGE_BITS = 8'hFE;
   localparam logic [7:0] BOX_SIDE_BITS = 8'h82;

   typedef struct packed {
      logic       command;
      logic [7:0] video_byte;
      logic [7:0] display_row;
      logic [9:0] font_address;
      logic [7:0] font_data;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic [3:0]  colour_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic       graphics_enable;
      logic [2:0] graphics_mode;
      logic       colour_set;
      logic       font_present;
   } cfg_type;

   typedef logic [LINE_PIXELS-1:0][3:0] line_type;

   // Decoded pixel run of one video byte; entry 0 is leftmost
   typedef struct packed {
      line_type line;
      logic     long_run;   // 16 pixels, else 8
   } pattern_type;

   function automatic logic [15:0] colour_rgb(input logic [3:0] ci);
      logic [15:0] rgb;
      unique case (ci)
         COLOUR_GREEN:   rgb = 16'h07E0;
         COLOUR_YELLOW:  rgb = 16'hFFE0;
         COLOUR_BLUE:    rgb = 16'h001F;
         COLOUR_RED:     rgb = 16'hF800;
         COLOUR_BUFF:    rgb = 16'hFFFF;
         COLOUR_CYAN:    rgb = 16'h07FF;
         COLOUR_MAGENTA: rgb = 16'hF81F;
         COLOUR_ORANGE:  rgb = 16'hFC00;
         default:        rgb = 16'h0000;
      endcase
      return rgb;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/vdg_pixel_generator.sv
// Top level of the alpha, semigraphics and graphics pixel generator.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | vdg_pkg::req_type (render or font write)
//   rsp_    | out       | rsp_valid / rsp_ready | vdg_pkg::rsp_type (one pixel)
//   csr_    | in        | csr_valid / csr_ready | csr_index, csr_wdata
//
// A render item gives 8 or 16 pixels, one per cycle while rsp_ready is
// high, so it occupies the pixel serializer until its last pixel is sent;
// that serializer sets the rate. The first pixel reaches rsp_valid through
// the row divide, font read, decode into the serializer and output register
// stages. Font writes give no pixels; they pass through the first three
// stages and are dropped in the third. Reset is synchronous and clears valid
// bits and config; the font store is not cleared. A stall on rsp_ready
// backs up through every stage to req_ready.
`default_nettype none

module vdg_pixel_generator #(
   parameter int FONT_ROWS = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,

   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire vdg_pkg::req_type req_data,

   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output vdg_pkg::rsp_type      rsp_data,

   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [7:0]       csr_wdata
);

   localparam int FONT_DEPTH  = vdg_pkg::GLYPH_COUNT * FONT_ROWS;
   localparam int FONT_ADDR_W = $clog2(FONT_DEPTH);
   localparam int ROW_W       = $clog2(FONT_ROWS);

   // ---------------- configuration registers ----------------
   vdg_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            vdg_pkg::CSR_GRAPHICS_ENABLE: cfg_in.graphics_enable = csr_wdata[0];
            vdg_pkg::CSR_GRAPHICS_MODE:   cfg_in.graphics_mode   = csr_wdata[2:0];
            vdg_pkg::CSR_COLOUR_SET:      cfg_in.colour_set      = csr_wdata[0];
            vdg_pkg::CSR_FONT_PRESENT:    cfg_in.font_present    = csr_wdata[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic p1_valid_ff, p1_valid_in;
   logic p2_valid_ff, p2_valid_in;
   logic p3_valid_ff, p3_valid_in;
   logic p1_move, p2_move, p3_move;
   logic ser_can_load, ser_load;
   logic p2_is_write, p3_is_write;

   vdg_pkg::req_type   p1_req_ff, p2_req_ff, p3_req_ff;
   logic [7:0]         p2_quot_ff;
   logic [ROW_W-1:0]   p3_row_ff;

   assign p2_is_write = (p2_req_ff.command == vdg_pkg::CMD_FONT_WRITE);
   assign p3_is_write = (p3_req_ff.command == vdg_pkg::CMD_FONT_WRITE);

   // stage 3 drops font writes, renders wait for the serializer
   assign ser_load  = p3_valid_ff && !p3_is_write && ser_can_load;
   assign p3_move   = p3_valid_ff && (p3_is_write || ser_can_load);
   assign p2_move   = p2_valid_ff && (!p3_valid_ff || p3_move);
   assign p1_move   = p1_valid_ff && (!p2_valid_ff || p2_move);
   assign req_ready = !p1_valid_ff || p1_move;

   assign p1_valid_in = (req_valid && req_ready) || (p1_valid_ff && !p1_move);
   assign p2_valid_in = p1_move || (p2_valid_ff && !p2_move);
   assign p3_valid_in = p2_move || (p3_valid_ff && !p3_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
         p3_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
         p3_valid_ff <= p3_valid_in;
      end
   end

   // ---------------- stage 1: row / cell height ----------------
   logic [7:0] p1_quot;

   vdg_row_divide #(.FONT_ROWS(FONT_ROWS)) u_row_divide (
      .row  (p1_req_ff.display_row),
      .quot (p1_quot)
   );

   // ---------------- stage 2: row in cell, font access ----------------
   logic [10:0]            q_term;
   logic [10:0]            glyph_term;
   logic [10:0]            render_addr;
   logic [7:0]             row_rem;
   logic                   font_we;
   logic [FONT_ADDR_W-1:0] font_addr;
   logic [7:0]             font_rdata;

   // glyph * rows + (row - quot * rows), all terms fit in 11 bits
   assign q_term      = 11'(p2_quot_ff) * 11'(FONT_ROWS);
   assign glyph_term  = 11'(p2_req_ff.video_byte[5:0]) * 11'(FONT_ROWS);
   assign render_addr = glyph_term + 11'(p2_req_ff.display_row) - q_term;
   assign row_rem     = p2_req_ff.display_row - q_term[7:0];

   // writes past the store are dropped
   assign font_we   = p2_is_write && ({1'b0, p2_req_ff.font_address} < 11'(FONT_DEPTH));
   assign font_addr = p2_is_write ? p2_req_ff.font_address[FONT_ADDR_W-1:0]
                                  : render_addr[FONT_ADDR_W-1:0];

   vdg_font_ram #(.DEPTH(FONT_DEPTH), .ADDR_W(FONT_ADDR_W)) u_font_ram (
      .clock (clock),
      .en    (p2_move),
      .we    (font_we),
      .addr  (font_addr),
      .wdata (p2_req_ff.font_data),
      .rdata (font_rdata)
   );

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         p1_req_ff <= req_data;
      end
      if (p1_move) begin
         p2_req_ff  <= p1_req_ff;
         p2_quot_ff <= p1_quot;
      end
      if (p2_move) begin
         p3_req_ff <= p2_req_ff;
         p3_row_ff <= row_rem[ROW_W-1:0];
      end
   end

   // ---------------- stage 3: decode ----------------
   vdg_pkg::pattern_type p3_pattern;

   vdg_pattern_gen #(.FONT_ROWS(FONT_ROWS), .ROW_W(ROW_W)) u_pattern_gen (
      .cfg        (cfg_ff),
      .video_byte (p3_req_ff.video_byte),
      .cell_row   (p3_row_ff),
      .font_data  (font_rdata),
      .pattern    (p3_pattern)
   );

   // ---------------- stage 4: pixel serializer + output register ----------------
   vdg_serializer u_serializer (
      .clock     (clock),
      .reset     (reset),
      .load      (ser_load),
      .pattern   (p3_pattern),
      .can_load  (ser_can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// File: hw/rtl/vdg_row_divide.sv
// Quotient of a display row by the character cell height, by reciprocal multiply.
`default_nettype none

module vdg_row_divide #(
   parameter int FONT_ROWS = 12
) (
   input  wire logic [7:0] row,
   output logic      [7:0] quot
);

   // ceil(2^16 / rows) is exact for any 8-bit row
   localparam int RECIP = (65536 + FONT_ROWS - 1) / FONT_ROWS;

   logic [23:0] prod;

   assign prod = 24'(row) * 24'(RECIP);
   assign quot = prod[23:16];

endmodule

`default_nettype wire

// File: hw/rtl/vdg_font_ram.sv
// Single-port character store with registered read.
`default_nettype none

module vdg_font_ram #(
   parameter int DEPTH  = 768,
   parameter int ADDR_W = 10
) (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [7:0]        wdata,
   output logic      [7:0]        rdata
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: hw/rtl/vdg_pattern_gen.sv
// Decodes one video byte into its run of color indexes for the current mode.
`default_nettype none

module vdg_pattern_gen #(
   parameter int FONT_ROWS = 12,
   parameter int ROW_W     = 4
) (
   input  wire vdg_pkg::cfg_type   cfg,
   input  wire logic [7:0]         video_byte,
   input  wire logic [ROW_W-1:0]   cell_row,
   input  wire logic [7:0]         font_data,
   output vdg_pkg::pattern_type    pattern
);

   localparam int BAND_ROWS = FONT_ROWS / 3;

   always_comb begin
      logic [3:0] semi_ci;
      logic [3:0] fg;
      logic [3:0] bg;
      logic [1:0] semi_bits;
      logic [7:0] glyph_bits;
      logic [3:0] set_base;

      pattern.long_run = 1'b0;
      for (int i = 0; i < vdg_pkg::LINE_PIXELS; i++) begin
         pattern.line[i] = vdg_pkg::COLOUR_BLACK;
      end
      set_base = cfg.colour_set ? vdg_pkg::COLOUR_BUFF : vdg_pkg::COLOUR_GREEN;
      semi_ci  = {1'b0, cfg.colour_set, video_byte[7:6]};

      // bottom band saturates
      if (cell_row >= ROW_W'(2 * BAND_ROWS)) begin
         semi_bits = video_byte[1:0];
      end else if (cell_row >= ROW_W'(BAND_ROWS)) begin
         semi_bits = video_byte[3:2];
      end else begin
         semi_bits = video_byte[5:4];
      end

      fg = cfg.colour_set ? vdg_pkg::COLOUR_ORANGE : vdg_pkg::COLOUR_GREEN;
      bg = vdg_pkg::COLOUR_BLACK;
      if (video_byte[7]) begin
         fg = vdg_pkg::COLOUR_BLACK;
         bg = cfg.colour_set ? vdg_pkg::COLOUR_ORANGE : vdg_pkg::COLOUR_GREEN;
      end

      // font columns 6..7 are background when a font is present
      if (cfg.font_present) begin
         glyph_bits = {font_data[5:0], 2'b00};
      end else if (cell_row == '0 || cell_row == ROW_W'(FONT_ROWS - 1)) begin
         glyph_bits = vdg_pkg::BOX_EDGE_BITS;
      end else begin
         glyph_bits = vdg_pkg::BOX_SIDE_BITS;
      end

      if (!cfg.graphics_enable) begin
         if (video_byte[6]) begin
            for (int i = 0; i < 4; i++) begin
               pattern.line[i]     = semi_bits[1] ? semi_ci : vdg_pkg::COLOUR_BLACK;
               pattern.line[i + 4] = semi_bits[0] ? semi_ci : vdg_pkg::COLOUR_BLACK;
            end
         end else begin
            for (int i = 0; i < 8; i++) begin
               pattern.line[i] = glyph_bits[7 - i] ? fg : bg;
            end
         end
      end else if (!cfg.graphics_mode[0]) begin
         // color graphics: four 2-bit pixels
         if (cfg.graphics_mode == vdg_pkg::GM_CG1) begin
            pattern.long_run = 1'b1;
            for (int i = 0; i < 16; i++) begin
               pattern.line[i] = set_base + {2'b00, video_byte[6 - 2 * (i / 4) +: 2]};
            end
         end else begin
            for (int i = 0; i < 8; i++) begin
               pattern.line[i] = set_base + {2'b00, video_byte[6 - 2 * (i / 2) +: 2]};
            end
         end
      end else begin
         // resolution graphics: eight 1-bit pixels
         if (cfg.graphics_mode == vdg_pkg::GM_RG6) begin
            for (int i = 0; i < 8; i++) begin
               pattern.line[i] = video_byte[7 - i] ? set_base : vdg_pkg::COLOUR_BLACK;
            end
         end else begin
            pattern.long_run = 1'b1;
            for (int i = 0; i < 16; i++) begin
               pattern.line[i] = video_byte[7 - i / 2] ? set_base : vdg_pkg::COLOUR_BLACK;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/vdg_serializer.sv
// Holds a decoded pixel run; sends one pixel per cycle unless stalled, via an output register.
`default_nettype none

module vdg_serializer (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire vdg_pkg::pattern_type pattern,
   output logic                      can_load,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output vdg_pkg::rsp_type          rsp_data
);

   logic               busy_ff, busy_in;
   logic [3:0]         pos_ff, pos_in;
   vdg_pkg::line_type  line_ff;
   logic               long_ff;
   logic               out_valid_ff, out_valid_in;
   vdg_pkg::rsp_type   out_ff;

   logic               emit;
   logic               last_px;
   logic [3:0]         cur_ci;

   assign last_px  = (pos_ff == (long_ff ? 4'd15 : 4'd7));
   assign emit     = busy_ff && (!out_valid_ff || rsp_ready);
   assign can_load = !busy_ff || (emit && last_px);
   assign cur_ci   = line_ff[pos_ff];

   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = '0;
      end else if (emit) begin
         busy_in = !last_px;
         pos_in  = pos_ff + 4'd1;
      end
      out_valid_in = emit || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         pos_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         line_ff <= pattern.line;
         long_ff <= pattern.long_run;
      end
      if (emit) begin
         out_ff.pixel        <= vdg_pkg::colour_rgb(cur_ci);
         out_ff.colour_index <= cur_ci;
         out_ff.last         <= last_px;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

// File: hw/rtl/vdg_port_checker.sv
// Port-level checks on the pixel generator, bound to its top level.
`default_nettype none

module vdg_port_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire vdg_pkg::rsp_type rsp_data
);

   // a stalled pixel stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("pixel changed while stalled");

   a_rsp_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.colour_index <= vdg_pkg::COLOUR_BLACK)
      else $error("color index out of range");

   a_rsp_rgb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pixel == vdg_pkg::colour_rgb(rsp_data.colour_index))
      else $error("pixel value does not match its color index");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("pixel shown right after reset");

   // an empty pipeline after reset takes an item at once
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("input not ready after reset");

endmodule

bind vdg_pixel_generator vdg_port_checker u_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
